// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, off during rst.
`define APA_ASSERT_IMPL(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on clk, off during rst.
`define APA_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/apa_pkg.sv -----
// Types, constants and tables of the antenna pointing angles block.
package apa_pkg;

  typedef struct packed {
    logic               op;
    logic [2:0]         fix_mode;
    logic signed [31:0] alt_cm;
    logic signed [31:0] east_cm;
    logic signed [31:0] north_cm;
    logic [39:0]        dist_sq_m2;
  } in_item_t;

  typedef struct packed {
    logic [15:0] azimuth_cdeg;
    logic [13:0] elevation_cdeg;
  } out_item_t;

  localparam logic       OP_GPS      = 1'b0;
  localparam logic       OP_NAV      = 1'b1;
  localparam logic [2:0] FIX_3D      = 3'd3;
  localparam logic       MODE_MANUAL = 1'b0;
  localparam logic       MODE_AUTO   = 1'b1;

  localparam logic REG_TRACKING_MODE = 1'b0;

  // CORDIC datapath: cm values scaled by 2^24, gain and sqrt(2) headroom
  localparam int CORDIC_W       = 60;
  localparam int PRESCALE_SHIFT = 24;
  localparam int STEP_LIMIT     = 40;

  localparam int ROOT_W     = 27;
  localparam int RADICAND_W = 54;
  localparam int ROOT_STEPS = 27;
  localparam int MUL_TERMS  = 5;

  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [15:0] FULL_CDEG    = 16'd36000;
  localparam logic [13:0] QUARTER_CDEG = 14'd9000;

  // atan(2^-i) in binary angle units, 2^32 per turn
  function automatic logic [31:0] step_angle(input logic [5:0] i);
    logic [31:0] a;
    case (i)
      6'd0:  a = 32'h20000000;
      6'd1:  a = 32'h12E4051E;
      6'd2:  a = 32'h09FB385B;
      6'd3:  a = 32'h051111D4;
      6'd4:  a = 32'h028B0D43;
      6'd5:  a = 32'h0145D7E1;
      6'd6:  a = 32'h00A2F61E;
      6'd7:  a = 32'h00517C55;
      6'd8:  a = 32'h0028BE53;
      6'd9:  a = 32'h00145F2F;
      6'd10: a = 32'h000A2F98;
      6'd11: a = 32'h000517CC;
      6'd12: a = 32'h00028BE6;
      6'd13: a = 32'h000145F3;
      6'd14: a = 32'h0000A2FA;
      6'd15: a = 32'h0000517D;
      6'd16: a = 32'h000028BE;
      6'd17: a = 32'h0000145F;
      6'd18: a = 32'h00000A30;
      6'd19: a = 32'h00000518;
      6'd20: a = 32'h0000028C;
      6'd21: a = 32'h00000146;
      6'd22: a = 32'h000000A3;
      6'd23: a = 32'h00000051;
      6'd24: a = 32'h00000029;
      6'd25: a = 32'h00000014;
      6'd26: a = 32'h0000000A;
      6'd27: a = 32'h00000005;
      6'd28: a = 32'h00000003;
      6'd29: a = 32'h00000001;
      6'd30: a = 32'h00000001;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

  // 10000 = 2^13 + 2^10 + 2^9 + 2^8 + 2^4
  function automatic logic [3:0] mul_shift(input logic [2:0] k);
    logic [3:0] s;
    case (k)
      3'd0: s = 4'd13;
      3'd1: s = 4'd10;
      3'd2: s = 4'd9;
      3'd3: s = 4'd8;
      3'd4: s = 4'd4;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/core/antenna_pointing_angles_unit.sv -----
// Top level of the antenna pointing angles block.
// Input channel item/item_valid/item_stall carries GPS status and navigation
// items. A GPS item updates the current altitude (and latches home altitude on
// the first 3D fix) in its accept cycle and produces nothing. A navigation item
// in automatic mode produces one result on result/result_valid/result_stall:
// azimuth and elevation in hundredths of a degree. In manual mode it produces
// nothing. tracking_mode is set through the APB port at byte address 0.
// From accept to result valid of a navigation item, the azimuth CORDIC pass
// runs beside the scale and square root, then the elevation pass follows once
// the root is ready; each pass ends with a conversion on the one shared
// multiplier. One item is in work at a time, so a new item is taken only once
// the result of the last one has been loaded into the output register;
// item_stall is high from accept until the result is registered. A finished
// result waits in the output register while the receiver stalls, and the next
// item is already accepted meanwhile.
// Synchronous reset clears mode, home altitude, lock and current altitude.
`include "assert_macros.svh"

module antenna_pointing_angles_unit #(
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  apa_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_stall,
  output apa_pkg::out_item_t result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CW = apa_pkg::CORDIC_W;
  localparam int PS = apa_pkg::PRESCALE_SHIFT;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_AZ_RUN  = 9'b000000010,
    S_AZ_MUL  = 9'b000000100,
    S_AZ_FIN  = 9'b000001000,
    S_SQ_WAIT = 9'b000010000,
    S_EL_RUN  = 9'b000100000,
    S_EL_MUL  = 9'b001000000,
    S_EL_FIN  = 9'b010000000,
    S_OUT     = 9'b100000000
  } state_t;

  state_t             state;
  logic               tracking_mode;
  logic signed [31:0] home_altitude;
  logic               home_locked;
  logic signed [31:0] current_altitude;

  logic               accept, nav_start, result_load;
  logic               zero_off, az_neg;
  logic signed [32:0] dz;
  logic [31:0]        conv_z;
  logic [47:0]        prod;
  logic [47:0]        prod_next;
  logic [15:0]        cdeg;
  logic [15:0]        az_res;
  logic [13:0]        el_res;

  logic                        cordic_start, cordic_done;
  logic signed [CW-1:0]        cordic_x, cordic_y;
  logic signed [CW-1:0]        north_w, east_w;
  logic signed [31:0]          cordic_z;
  logic                        sq_ready;
  logic [apa_pkg::ROOT_W-1:0]  sq_root;

  assign pready     = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign nav_start  = accept && (item.op == apa_pkg::OP_NAV) &&
                      (tracking_mode == apa_pkg::MODE_AUTO);
  assign result_load = (state == S_OUT) && !(result_valid && result_stall);
  assign prod_next  = 48'(conv_z) * 48'(apa_pkg::FULL_CDEG) + 48'(apa_pkg::HALF_TURN);
  assign cdeg       = prod[47:32];

  always_comb begin
    unique case (paddr[2])
      apa_pkg::REG_TRACKING_MODE: prdata = {31'b0, tracking_mode};
      default:                    prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracking_mode <= apa_pkg::MODE_MANUAL;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == apa_pkg::REG_TRACKING_MODE) begin
      tracking_mode <= pwdata[0];
    end
  end

  // CORDIC operands: azimuth vector at accept, elevation vector after the root
  always_comb begin
    north_w = CW'(item.north_cm) <<< PS;
    east_w  = CW'(item.east_cm) <<< PS;
    if (state == S_SQ_WAIT) begin
      cordic_x = CW'(sq_root) << PS;
      cordic_y = CW'(dz) <<< PS;
    end else if (item.north_cm < 0) begin
      cordic_x = -north_w;
      cordic_y = -east_w;
    end else begin
      cordic_x = north_w;
      cordic_y = east_w;
    end
    cordic_start = nav_start || (state == S_SQ_WAIT && sq_ready);
  end

  apa_cordic #(
    .ITER (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .x_in  (cordic_x),
    .y_in  (cordic_y),
    .done  (cordic_done),
    .z     (cordic_z)
  );

  apa_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (nav_start),
    .dsq   (item.dist_sq_m2),
    .ready (sq_ready),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      home_altitude    <= 32'sd0;
      home_locked      <= 1'b0;
      current_altitude <= 32'sd0;
      result_valid     <= 1'b0;
    end else begin
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && item.op == apa_pkg::OP_GPS) begin
            if (!home_locked && item.fix_mode == apa_pkg::FIX_3D) begin
              home_altitude <= item.alt_cm;
              home_locked   <= 1'b1;
            end
            current_altitude <= item.alt_cm;
          end
          if (nav_start) begin
            zero_off <= (item.east_cm == 0) && (item.north_cm == 0);
            az_neg   <= item.north_cm < 0;
            dz       <= 33'(current_altitude) - 33'(home_altitude);
            state    <= S_AZ_RUN;
          end
        end
        S_AZ_RUN: begin
          if (cordic_done) begin
            conv_z <= (az_neg ? apa_pkg::HALF_TURN : 32'h0) + cordic_z;
            state  <= S_AZ_MUL;
          end
        end
        S_AZ_MUL: begin
          prod  <= prod_next;
          state <= S_AZ_FIN;
        end
        S_AZ_FIN: begin
          // a rounded full turn wraps to north
          az_res <= (zero_off || cdeg >= apa_pkg::FULL_CDEG) ? 16'd0 : cdeg;
          state  <= S_SQ_WAIT;
        end
        S_SQ_WAIT: begin
          if (sq_ready) begin
            state <= S_EL_RUN;
          end
        end
        S_EL_RUN: begin
          if (cordic_done) begin
            if (cordic_z < 0) begin
              conv_z <= 32'h0;
            end else if (cordic_z > $signed(apa_pkg::QUARTER_TURN)) begin
              conv_z <= apa_pkg::QUARTER_TURN;
            end else begin
              conv_z <= cordic_z;
            end
            state <= S_EL_MUL;
          end
        end
        S_EL_MUL: begin
          prod  <= prod_next;
          state <= S_EL_FIN;
        end
        S_EL_FIN: begin
          if (dz <= 0) begin
            el_res <= 14'd0;
          end else if (sq_root == '0) begin
            el_res <= apa_pkg::QUARTER_CDEG;     // straight overhead
          end else if (cdeg > 16'(apa_pkg::QUARTER_CDEG)) begin
            el_res <= apa_pkg::QUARTER_CDEG;
          end else begin
            el_res <= cdeg[13:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (result_load) begin
            result.azimuth_cdeg   <= az_res;
            result.elevation_cdeg <= el_res;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `APA_ASSERT_IMPL(a_done_in_run, cordic_done, state == S_AZ_RUN || state == S_EL_RUN)
  `APA_ASSERT_IMPL(a_el_after_root, state == S_EL_RUN, sq_ready)
  `APA_ASSERT_IMPL(a_no_overwrite, result_load, !(result_valid && result_stall))
  `APA_ASSERT_IMPL(a_result_range, result_valid,
                   result.azimuth_cdeg < apa_pkg::FULL_CDEG &&
                   result.elevation_cdeg <= apa_pkg::QUARTER_CDEG)
  `APA_ASSERT_NEXT(a_start_runs, nav_start, state == S_AZ_RUN && !sq_ready)

endmodule

// ----- rtl/core/apa_cordic.sv -----
// Iterative vectoring CORDIC, one micro-rotation per cycle.
module apa_cordic #(
  parameter int ITER = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [apa_pkg::CORDIC_W-1:0] x_in,
  input  logic signed [apa_pkg::CORDIC_W-1:0] y_in,
  output logic                                done,
  output logic signed [31:0]                  z
);

  localparam int CW    = apa_pkg::CORDIC_W;
  localparam int CNT_W = $clog2(ITER);

  logic signed [CW-1:0] x, y, dx, dy;
  logic [CNT_W-1:0]     i;
  logic                 running;
  logic signed [31:0]   angle;

  always_comb begin
    dx    = y >>> i;
    dy    = x >>> i;
    angle = $signed(apa_pkg::step_angle(6'(i)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x       <= x_in;
        y       <= y_in;
        z       <= 32'sd0;
        i       <= '0;
        running <= 1'b1;
      end else if (running) begin
        if (y > 0) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + angle;
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - angle;
        end
        i <= i + 1'b1;
        if (i == CNT_W'(ITER - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/apa_isqrt.sv -----
// Scales the squared distance to cm^2 by shift-add and takes its integer square root.
module apa_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [39:0]                 dsq,
  output logic                        ready,
  output logic [apa_pkg::ROOT_W-1:0]  root
);

  localparam int RW = apa_pkg::RADICAND_W;

  typedef enum logic [2:0] {
    Q_IDLE = 3'b001,
    Q_MUL  = 3'b010,
    Q_ROOT = 3'b100
  } sq_state_t;

  sq_state_t     state;
  logic [RW-1:0] acc;
  logic [RW-1:0] r;
  logic [39:0]   d;
  logic [2:0]    cnt;
  logic [4:0]    k;
  logic [RW:0]   bit_val;
  logic [RW:0]   trial;
  logic [RW-1:0] term;

  always_comb begin
    term    = RW'(d) << apa_pkg::mul_shift(cnt);
    bit_val = (RW + 1)'(1) << {k, 1'b0};
    trial   = {1'b0, r} + bit_val;
  end

  assign root = r[apa_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Q_IDLE;
      ready <= 1'b0;
    end else begin
      unique case (state)
        Q_IDLE: begin
          if (start) begin
            d     <= dsq;
            acc   <= '0;
            r     <= '0;
            cnt   <= '0;
            ready <= 1'b0;
            state <= Q_MUL;
          end
        end
        Q_MUL: begin
          acc <= acc + term;
          cnt <= cnt + 1'b1;
          if (cnt == 3'(apa_pkg::MUL_TERMS - 1)) begin
            k     <= 5'(apa_pkg::ROOT_STEPS - 1);
            state <= Q_ROOT;
          end
        end
        Q_ROOT: begin
          if ({1'b0, acc} >= trial) begin
            acc <= acc - trial[RW-1:0];
            r   <= (r >> 1) + bit_val[RW-1:0];
          end else begin
            r <= r >> 1;
          end
          k <= k - 1'b1;
          if (k == 5'd0) begin
            ready <= 1'b1;
            state <= Q_IDLE;
          end
        end
        default: state <= Q_IDLE;
      endcase
    end
  end

endmodule
